### src/med3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 median filter.
// No dependencies; imported by every module of the block but med3_ram.
package med3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 8;
    localparam int CFG_BITS       = 11;
    localparam int CFG_IDX_BITS   = 1;
    localparam int MAX_HEIGHT     = 1024;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // per-word control that rides with a pixel from the counters to the window
    typedef struct packed {
        logic wrap;       // column 0: result is for the last column of a prior row
        logic pad_top;
        logic pad_bot;
        logic pad_left;
        logic pad_right;
        logic last;
        logic emit;
    } t_pos_ctl;

endpackage

### src/med3_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module med3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/med3_line.sv
`timescale 1ns / 1ps
// Line stores (one RAM holding upper and middle rows), 3x3 window and
// edge padding. Depends on med3_pkg and med3_ram.
module med3_line
    import med3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_acc,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  logic [PIXEL_BITS-1:0]        i_pix,
    input  t_pos_ctl                     i_ctl,
    output logic                         o_valid,
    output logic                         o_last,
    output logic [PIXEL_BITS-1:0]        o_nb [9]
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PB = PIXEL_BITS;

    logic          r_s1_valid;
    logic [CW-1:0] r_s1_addr;
    logic [PB-1:0] r_s1_pix;
    t_pos_ctl      r_s1_ctl;

    logic            r_fwd_hit;
    logic [2*PB-1:0] r_fwd_data;
    logic [2*PB-1:0] ram_q;
    logic [2*PB-1:0] rd;
    logic [2*PB-1:0] wdata;
    logic            we;

    logic [PB-1:0] col_in [3];
    logic [PB-1:0] r_win  [3][3];
    logic [PB-1:0] nb     [9];
    logic [PB-1:0] r_nb   [9];
    logic          r_s2_valid;
    logic          r_s2_last;

    // stage 1: line store read returns; write back shifted column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_acc;
            // width of one: next word reads the entry being written now
            r_fwd_hit  <= r_s1_valid && i_acc && (i_addr == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fwd_data <= wdata;
            if (i_acc) begin
                r_s1_addr <= i_addr;
                r_s1_pix  <= i_pix;
                r_s1_ctl  <= i_ctl;
            end
        end
    end

    assign rd    = r_fwd_hit ? r_fwd_data : ram_q;
    assign wdata = {rd[PB-1:0], r_s1_pix};
    assign we    = i_en && r_s1_valid;

    med3_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_addr),
        .i_wdata (wdata),
        .i_re    (i_acc),
        .i_raddr (i_addr),
        .o_rdata (ram_q)
    );

    assign col_in[0] = rd[2*PB-1:PB];
    assign col_in[1] = rd[PB-1:0];
    assign col_in[2] = r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[i][k] <= '0;
                end
            end
        end else if (we) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
                r_win[i][2] <= col_in[i];
            end
        end
    end

    // neighborhood of the result pixel, outside samples forced to zero
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nb[i*3]     = r_win[i][1];
            nb[i*3 + 1] = r_win[i][2];
            nb[i*3 + 2] = r_s1_ctl.wrap ? '0 : col_in[i];
        end
        for (int k = 0; k < 3; k++) begin
            if (r_s1_ctl.pad_top) nb[k] = '0;
            if (r_s1_ctl.pad_bot) nb[6 + k] = '0;
            if (r_s1_ctl.pad_left) nb[k*3] = '0;
            if (r_s1_ctl.pad_right) nb[k*3 + 2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid && r_s1_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_last <= r_s1_ctl.last;
            r_nb      <= nb;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_last  = r_s2_last;
    assign o_nb    = r_nb;

endmodule

### src/med3_sort.sv
`timescale 1ns / 1ps
// Median-of-nine compare-exchange network in three register stages.
// Depends on med3_pkg.
module med3_sort
    import med3_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic                  i_last,
    input  logic [PIXEL_BITS-1:0] i_px [9],
    output logic                  o_valid,
    output logic                  o_last,
    output logic [PIXEL_BITS-1:0] o_median
);

    localparam int PB = PIXEL_BITS;

    logic [PB-1:0] a [9];
    logic [PB-1:0] b [9];
    logic [PB-1:0] c [9];
    logic [PB-1:0] r_a [9];
    logic [PB-1:0] r_b [9];
    logic [PB-1:0] r_med;
    logic [2:0]    r_valid;
    logic [2:0]    r_last;

    // returns {max, min}
    function automatic logic [2*PB-1:0] cx(input logic [PB-1:0] x, input logic [PB-1:0] y);
        return (x > y) ? {x, y} : {y, x};
    endfunction

    always_comb begin
        a = i_px;
        {a[2], a[1]} = cx(a[1], a[2]);
        {a[5], a[4]} = cx(a[4], a[5]);
        {a[8], a[7]} = cx(a[7], a[8]);
        {a[1], a[0]} = cx(a[0], a[1]);
        {a[4], a[3]} = cx(a[3], a[4]);
        {a[7], a[6]} = cx(a[6], a[7]);
        {a[2], a[1]} = cx(a[1], a[2]);
        {a[5], a[4]} = cx(a[4], a[5]);
        {a[8], a[7]} = cx(a[7], a[8]);
    end

    always_comb begin
        b = r_a;
        {b[3], b[0]} = cx(b[0], b[3]);
        {b[8], b[5]} = cx(b[5], b[8]);
        {b[7], b[4]} = cx(b[4], b[7]);
        {b[6], b[3]} = cx(b[3], b[6]);
        {b[4], b[1]} = cx(b[1], b[4]);
        {b[5], b[2]} = cx(b[2], b[5]);
        {b[7], b[4]} = cx(b[4], b[7]);
    end

    always_comb begin
        c = r_b;
        {c[2], c[4]} = cx(c[4], c[2]);
        {c[4], c[6]} = cx(c[6], c[4]);
        {c[2], c[4]} = cx(c[4], c[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last <= {r_last[1:0], i_last};
            r_a    <= a;
            r_b    <= b;
            r_med  <= c[4];
        end
    end

    assign o_valid  = r_valid[2];
    assign o_last   = r_last[2];
    assign o_median = r_med;

endmodule

### src/median_filter_3x3_unit.sv
`timescale 1ns / 1ps
// Top level of the streaming 3x3 median filter with zero padding.
// Depends on med3_pkg, med3_line (with med3_ram) and med3_sort.
//
// Usage:
//  - s_axis: one pixel per word in raster order (tdata = pixel, tuser =
//    flush flag). After a frame of width*height pixels the source sends
//    width+1 flush words to drain the last results.
//  - m_axis: one median per result word, tlast on the frame's last pixel.
//    Results trail the input by one line plus one pixel of words.
//  - cfg: write channel, index 0 = image width, index 1 = image height.
//    Always ready; a write restarts the frame. Write only while idle.
// Throughput: one word per clock while the skid register is empty. The line
//  stores are one RAM, read at accept and written back from the stage 1
//  register; with a width of one the next word picks up the written entry
//  through a forward register. Path: a result moves through the stage 1,
//  neighborhood, sort and output registers after its last word is accepted.
// Stall: a skid register behind the output register absorbs the result in
//  flight; s_axis_tready drops only while the skid register is full.
// Reset (synchronous, active low): width 640, height 480, counters, window
//  and valid flags cleared. The line store RAM is not cleared.
module median_filter_3x3_unit
    import med3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,  // pixel
    input  logic                            s_axis_tuser,  // is_flush
    // stream out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0] m_axis_tdata,  // median
    output logic                            m_axis_tlast,  // frame_last
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [CFG_BITS-1:0]             i_cfg_data
);

    localparam int PB  = PIXEL_BITS;
    localparam int TDW = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = CW + 1;
    localparam int EW  = (WW > CFG_BITS) ? WW : CFG_BITS;

    // configuration
    logic [CFG_BITS-1:0] r_cfg_width;
    logic [CFG_BITS-1:0] r_cfg_height;
    logic                cfg_acc;

    logic [EW-1:0]       w_ext;
    logic [WW-1:0]       w_eff;
    logic [CW-1:0]       w_m1;
    logic [CFG_BITS-1:0] h_eff;
    logic [CFG_BITS-1:0] h_m1;

    // input position
    logic [CW-1:0]       r_in_col;
    logic [CFG_BITS-1:0] r_in_row;
    logic [CW-1:0]       n_in_col;
    logic [CFG_BITS-1:0] n_in_row;
    logic [CW-1:0]       col;
    logic [CFG_BITS-1:0] orow;
    logic [CW-1:0]       ocol;
    t_pos_ctl            ctl;

    logic                en;
    logic                acc;
    logic [PB-1:0]       pix;

    logic                nb_valid;
    logic                nb_last;
    logic [PB-1:0]       nb [9];
    logic                srt_valid;
    logic                srt_last;
    logic [PB-1:0]       srt_med;

    logic                r_out_valid;
    logic                r_out_last;
    logic [PB-1:0]       r_out_med;
    logic                r_skid_valid;
    logic                r_skid_last;
    logic [PB-1:0]       r_skid_med;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_BITS'(WIDTH_RESET);
            r_cfg_height <= CFG_BITS'(HEIGHT_RESET);
        end else if (cfg_acc) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // out-of-range sizes clamp: zero acts as one, oversize as the maximum
    always_comb begin
        w_ext = EW'(r_cfg_width);
        if (w_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext[WW-1:0];
        end
        if (r_cfg_height == '0) begin
            h_eff = CFG_BITS'(1);
        end else if (r_cfg_height > CFG_BITS'(MAX_HEIGHT)) begin
            h_eff = CFG_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_height;
        end
    end

    assign w_m1 = CW'(w_eff - WW'(1));
    assign h_m1 = h_eff - CFG_BITS'(1);

    // pipeline moves unless the skid register holds a result
    assign en            = !r_skid_valid;
    assign s_axis_tready = en;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign pix           = s_axis_tuser ? '0 : s_axis_tdata[PB-1:0];

    // position of this word and of the result it completes
    always_comb begin
        col = ({1'b0, r_in_col} >= w_eff) ? '0 : r_in_col;
        if (col != '0) begin
            orow     = r_in_row - CFG_BITS'(1);
            ocol     = col - CW'(1);
            ctl.emit = (r_in_row != '0);
        end else begin
            orow     = r_in_row - CFG_BITS'(2);
            ocol     = w_m1;
            ctl.emit = (r_in_row >= CFG_BITS'(2));
        end
        ctl.wrap      = (col == '0);
        ctl.pad_top   = (orow == '0);
        ctl.pad_bot   = (orow >= h_m1);
        ctl.pad_left  = (ocol == '0);
        ctl.pad_right = (ocol == w_m1);
        ctl.last      = ctl.emit && (orow == h_m1) && (ocol == w_m1);

        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (cfg_acc) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (acc) begin
            if (ctl.last) begin
                n_in_col = '0;
                n_in_row = '0;
            end else if (col == w_m1) begin
                n_in_col = '0;
                n_in_row = r_in_row + CFG_BITS'(1);
            end else begin
                n_in_col = col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
        end
    end

    med3_line #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_acc   (acc),
        .i_addr  (col),
        .i_pix   (pix),
        .i_ctl   (ctl),
        .o_valid (nb_valid),
        .o_last  (nb_last),
        .o_nb    (nb)
    );

    med3_sort #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_sort (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (nb_valid),
        .i_last   (nb_last),
        .i_px     (nb),
        .o_valid  (srt_valid),
        .o_last   (srt_last),
        .o_median (srt_med)
    );

    // output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (srt_valid) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_med  <= r_skid_med;
                r_out_last <= r_skid_last;
            end
        end else if (srt_valid) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_med  <= srt_med;
                r_skid_last <= srt_last;
            end else begin
                r_out_med  <= srt_med;
                r_out_last <= srt_last;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDW'(r_out_med);
    assign m_axis_tlast  = r_out_last;

    // skid holds data only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register valid with empty output register");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready))
        else $error("skid register loaded without output stall");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_in_col} < w_eff)
        else $error("input column beyond image width");

    a_last_resets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && ctl.last) |=> (r_in_col == '0 && r_in_row == '0))
        else $error("position not restarted after frame end");

endmodule
